### rtl/ddo_pkg.sv
`timescale 1ns / 1ps
// Shared constants and helpers for the differential drive odometry block.
// No dependencies.
package ddo_pkg;

    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 216;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int PROD_W     = 66;
    localparam int CRD_W      = 34;
    localparam int IT_W       = 5;

    localparam logic [CFG_IDX_W-1:0] REG_METRES_PER_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_WHEEL_BASE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_LEFT      = 2'd3;

    localparam logic signed [CRD_W-1:0] PI_Q      = 34'sd205887;
    localparam logic signed [CRD_W-1:0] TWO_PI_Q  = 34'sd411774;
    localparam logic signed [CRD_W-1:0] HALF_PI_Q = 34'sd102944;
    localparam logic signed [CRD_W-1:0] GAIN_Q30  = 34'sd652032874;

    // Micro-operations of the shared multiplier
    typedef enum logic [3:0] {
        OP_RIGHT_M, OP_LEFT_M, OP_TURN, OP_VR, OP_VL, OP_VLIN, OP_VANG,
        OP_X, OP_Y
    } t_op;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        begin
            if (v > $signed({{(PROD_W-32){1'b0}}, 32'h7FFF_FFFF}))
                r = 32'sh7FFF_FFFF;
            else if (v < $signed({{(PROD_W-32){1'b1}}, 32'h8000_0000}))
                r = 32'sh8000_0000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

    // Wrap a heading once into +-pi, then clamp
    function automatic logic signed [18:0] wrap_heading(input logic signed [CRD_W-1:0] h);
        logic signed [CRD_W-1:0] t;
        begin
            t = h;
            if (t > PI_Q) t = t - TWO_PI_Q;
            if (t < -PI_Q) t = t + TWO_PI_Q;
            if (t > PI_Q) t = PI_Q;
            if (t < -PI_Q) t = -PI_Q;
            return t[18:0];
        end
    endfunction

    // Arctangent of 2^-i, Q2.30
    function automatic logic signed [CRD_W-1:0] atan_q30(input logic [IT_W-1:0] i);
        logic signed [CRD_W-1:0] r;
        begin
            case (i)
                5'd0:  r = 34'sd843314856;
                5'd1:  r = 34'sd497837829;
                5'd2:  r = 34'sd263043836;
                5'd3:  r = 34'sd133525158;
                5'd4:  r = 34'sd67021686;
                5'd5:  r = 34'sd33543515;
                5'd6:  r = 34'sd16775850;
                5'd7:  r = 34'sd8388437;
                5'd8:  r = 34'sd4194282;
                5'd9:  r = 34'sd2097149;
                5'd10: r = 34'sd1048575;
                5'd11: r = 34'sd524287;
                5'd12: r = 34'sd262143;
                5'd13: r = 34'sd131071;
                5'd14: r = 34'sd65535;
                5'd15: r = 34'sd32767;
                5'd16: r = 34'sd16383;
                5'd17: r = 34'sd8191;
                5'd18: r = 34'sd4095;
                5'd19: r = 34'sd2047;
                5'd20: r = 34'sd1023;
                5'd21: r = 34'sd511;
                5'd22: r = 34'sd255;
                5'd23: r = 34'sd127;
                5'd24: r = 34'sd63;
                5'd25: r = 34'sd31;
                5'd26: r = 34'sd15;
                5'd27: r = 34'sd8;
                5'd28: r = 34'sd4;
                5'd29: r = 34'sd2;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

### rtl/differential_drive_odometry.sv
`timescale 1ns / 1ps
// Top level of the differential drive odometry block.
// Depends on ddo_pkg.
//
// Usage:
//   Slave stream: tuser carries kind (0 encoder sample, 1 set pose); tdata
//   carries the counts and the pose to load. Master stream: one result per
//   input transfer with the pose and the four speeds.
//   Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is
//   high (0 metres per count, 1 inverse wheel base, 2 sample rate,
//   3 invert left). Write only while the block is idle.
// Sequence and throughput:
//   An encoder sample runs CORDIC_STEPS steps of sine/cosine rotation
//   on one shift-add stage, then goes to the shared 33x33 multiplier
//   (9 products, each a multiply state and a consume state), then the result
//   is shown. A set-pose item loads the pose and goes straight to the result.
//   One item is in work at a time; tready is low until the result is taken.
// Reset: pose, previous wheel positions and speeds clear to zero and the
//   registers load their defaults.
// Stall: the result holds on the master side until tready is seen high.
module differential_drive_odometry #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // right_count[31:0], left_count[63:32], set_x[95:64], set_y[127:96],
    // set_heading[146:128], zero pad
    input  logic [ddo_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // pos_x[31:0], pos_y[63:32], heading[82:64], right_speed[114:83],
    // left_speed[146:115], linear_speed[178:147], angular_speed[210:179], pad
    output logic [ddo_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           i_cfg_we,
    input  logic [ddo_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ddo_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ddo_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_ROT, S_MUL, S_USE, S_OUT} t_state;

    t_state r_state;
    t_op    r_op;
    logic [IT_W-1:0] r_it;

    logic [31:0]        r_mpc;
    logic [30:0]        r_iwb;
    logic [15:0]        r_rate;
    logic               r_inv;

    logic signed [31:0] r_prev_r, r_prev_l, r_x, r_y;
    logic signed [18:0] r_head;
    logic signed [31:0] r_vr, r_vl, r_vlin, r_vang;

    logic signed [31:0] r_rc, r_lc, r_rm, r_dr, r_dl, r_step, r_turn;
    logic signed [CRD_W-1:0] r_cx, r_cy, r_cz;
    logic               r_flip;
    logic signed [32:0] r_cos, r_sin;
    logic signed [PROD_W-1:0] r_prod;

    logic signed [32:0] n_mul_a, n_mul_b;
    logic signed [31:0] n_diff;
    logic signed [CRD_W-1:0] n_xs, n_ys, n_ang, n_cx, n_cy;
    logic               n_flip;
    logic signed [PROD_W-1:0] n_lm;
    logic signed [31:0] n_l32;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {5'b0, r_vang, r_vlin, r_vl, r_vr, r_head, r_y, r_x};

    // Select multiplier operands for the current micro-operation
    always_comb begin
        n_diff = sat32(PROD_W'(r_dr) - PROD_W'(r_dl));
        case (r_op)
            OP_RIGHT_M: begin n_mul_a = 33'(r_rc);   n_mul_b = {1'b0, r_mpc}; end
            OP_LEFT_M:  begin n_mul_a = 33'(r_lc);   n_mul_b = {1'b0, r_mpc}; end
            OP_TURN:    begin n_mul_a = 33'(n_diff); n_mul_b = {2'b0, r_iwb}; end
            OP_VR:      begin n_mul_a = 33'(r_dr);   n_mul_b = {17'b0, r_rate}; end
            OP_VL:      begin n_mul_a = 33'(r_dl);   n_mul_b = {17'b0, r_rate}; end
            OP_VLIN:    begin n_mul_a = 33'(r_step); n_mul_b = {17'b0, r_rate}; end
            OP_VANG:    begin n_mul_a = 33'(r_turn); n_mul_b = {17'b0, r_rate}; end
            OP_X:       begin n_mul_a = 33'(r_step); n_mul_b = r_cos; end
            OP_Y:       begin n_mul_a = 33'(r_step); n_mul_b = r_sin; end
            default:    begin n_mul_a = '0;          n_mul_b = '0; end
        endcase
    end

    // Rotation setup, shift terms and left wheel scaling
    always_comb begin
        n_flip = 1'b0;
        n_ang  = CRD_W'(r_head);
        if (n_ang > HALF_PI_Q) begin
            n_ang  = n_ang - PI_Q;
            n_flip = 1'b1;
        end else if (n_ang < -HALF_PI_Q) begin
            n_ang  = n_ang + PI_Q;
            n_flip = 1'b1;
        end
        n_xs = r_cx >>> r_it;
        n_ys = r_cy >>> r_it;
        if (r_cz >= 0) begin
            n_cx = r_cx - n_ys;
            n_cy = r_cy + n_xs;
        end else begin
            n_cx = r_cx + n_ys;
            n_cy = r_cy - n_xs;
        end
        n_lm  = r_prod >>> 16;
        if (r_inv) n_lm = -n_lm;
        n_l32 = sat32(n_lm);
    end

    // Sequencer, datapath registers and pose state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_RIGHT_M;
            r_it     <= '0;
            r_mpc    <= 32'd429497;
            r_iwb    <= 31'd655360;
            r_rate   <= 16'd250;
            r_inv    <= 1'b1;
            r_prev_r <= '0;
            r_prev_l <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_head   <= '0;
            r_vr     <= '0;
            r_vl     <= '0;
            r_vlin   <= '0;
            r_vang   <= '0;
        end else begin
            // Register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_METRES_PER_COUNT: r_mpc  <= i_cfg_data;
                    REG_INV_WHEEL_BASE:   r_iwb  <= i_cfg_data[30:0];
                    REG_SAMPLE_RATE:      r_rate <= i_cfg_data[15:0];
                    REG_INVERT_LEFT:      r_inv  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        if (s_axis_tuser) begin
                            r_x    <= s_axis_tdata[95:64];
                            r_y    <= s_axis_tdata[127:96];
                            r_head <= wrap_heading(CRD_W'($signed(s_axis_tdata[146:128])));
                            r_vr   <= '0;
                            r_vl   <= '0;
                            r_vlin <= '0;
                            r_vang <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_rc   <= s_axis_tdata[31:0];
                            r_lc   <= s_axis_tdata[63:32];
                            r_cx   <= GAIN_Q30;
                            r_cy   <= '0;
                            r_cz   <= n_ang <<< 14;
                            r_flip <= n_flip;
                            r_it   <= '0;
                            r_state <= S_ROT;
                        end
                    end
                end
                S_ROT: begin
                    // One rotation step per cycle
                    r_cx <= n_cx;
                    r_cy <= n_cy;
                    r_cz <= (r_cz >= 0) ? r_cz - atan_q30(r_it) : r_cz + atan_q30(r_it);
                    r_it <= r_it + 1'b1;
                    if (r_it == IT_W'(CORDIC_STEPS - 1)) begin
                        r_cos   <= r_flip ? -33'(n_cx) : 33'(n_cx);
                        r_sin   <= r_flip ? -33'(n_cy) : 33'(n_cy);
                        r_op    <= OP_RIGHT_M;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(n_mul_a) * PROD_W'(n_mul_b);
                    r_state <= S_USE;
                end
                S_USE: begin
                    // Consume the product of the current operation
                    r_state <= S_MUL;
                    r_op    <= t_op'(r_op + 1'b1);
                    case (r_op)
                        OP_RIGHT_M: r_rm <= sat32(r_prod >>> 16);
                        OP_LEFT_M: begin
                            r_dr     <= sat32(PROD_W'(r_rm) - PROD_W'(r_prev_r));
                            r_dl     <= sat32(PROD_W'(n_l32) - PROD_W'(r_prev_l));
                            r_prev_r <= r_rm;
                            r_prev_l <= n_l32;
                        end
                        OP_TURN: begin
                            r_turn <= sat32(r_prod >>> 16);
                            r_step <= 32'((33'(r_dr) + 33'(r_dl)) >>> 1);
                        end
                        OP_VR:   r_vr   <= sat32(r_prod);
                        OP_VL:   r_vl   <= sat32(r_prod);
                        OP_VLIN: r_vlin <= sat32(r_prod);
                        OP_VANG: r_vang <= sat32(r_prod);
                        OP_X:    r_x    <= sat32(PROD_W'(r_x) + (r_prod >>> 30));
                        OP_Y: begin
                            r_y     <= sat32(PROD_W'(r_y) + (r_prod >>> 30));
                            r_head  <= wrap_heading(CRD_W'(r_head) + CRD_W'(r_turn));
                            r_state <= S_OUT;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_OUT: begin
                    if (m_axis_tready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for differential_drive_odometry: stream stimulus,
// a pose predictor, and field-by-field result checks. Depends on ddo_pkg.
module testbench;
    import ddo_pkg::*;

    localparam int PI_HDG = 205887;
    localparam int HALF_PI_HDG = 102944;
    localparam int N_RANDOM = 630;
    localparam int IDLE_LIMIT = 20000;
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_SET_POSE = 1'b1;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [18:0] hdg;
        logic signed [31:0] vr;
        logic signed [31:0] vl;
        logic signed [31:0] vlin;
        logic signed [31:0] vang;
    } pose_t;

    typedef struct {
        logic        kind;
        logic [31:0] rc;
        logic [31:0] lc;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [18:0] sh;
        logic        has_pose;
        pose_t       pose;
    } row_t;

    logic i_clk, i_rst_n;
    logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic m_axis_tvalid, m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    differential_drive_odometry DUT (.*);

    // Predictor state and registers
    longint mpc, iwb, rate, inv_left;
    longint prev_r, prev_l, px, py, ph;
    pose_t pose_q[$];
    int errors = 0;
    int idle_cycles = 0;
    bit hold_rx = 0;
    bit long_hold = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint wrap_hdg(longint h);
        if (h > PI_HDG) h -= 2 * PI_HDG;
        if (h < -PI_HDG) h += 2 * PI_HDG;
        if (h > PI_HDG) h = PI_HDG;
        if (h < -PI_HDG) h = -PI_HDG;
        return h;
    endfunction

    function automatic longint atan_tab(int i);
        longint t[30] = '{843314856, 497837829, 263043836, 133525158, 67021686,
            33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
            262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511,
            255, 127, 63, 31, 15, 8, 4, 2};
        return t[i];
    endfunction

    // Rotate the gain vector to the heading; fold outside +-pi/2
    task automatic sin_cos(input longint hdg, output longint c, output longint s);
        longint a, x, y, z, xs, ys;
        bit flip;
        a = hdg;
        flip = 0;
        if (a > HALF_PI_HDG) begin
            a -= PI_HDG; flip = 1;
        end else if (a < -HALF_PI_HDG) begin
            a += PI_HDG; flip = 1;
        end
        x = 652032874; y = 0; z = a * 16384;
        for (int i = 0; i < 16; i++) begin
            xs = fshr(x, i); ys = fshr(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_tab(i);
            end else begin
                x += ys; y -= xs; z += atan_tab(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic odometry_step(input row_t r, output pose_t p);
        longint rm, lm, dr, dl, step, turn, c, s;
        p = '0;
        if (r.kind == KIND_SET_POSE) begin
            px = longint'($signed(r.sx));
            py = longint'($signed(r.sy));
            ph = wrap_hdg(longint'($signed(r.sh)));
        end else begin
            rm = fshr(longint'($signed(r.rc)) * mpc, 16);
            lm = fshr(longint'($signed(r.lc)) * mpc, 16);
            if (inv_left != 0) lm = -lm;
            rm = clamp32(rm); lm = clamp32(lm);
            dr = clamp32(rm - prev_r);
            dl = clamp32(lm - prev_l);
            prev_r = rm; prev_l = lm;
            step = fshr(dr + dl, 1);
            turn = clamp32(fshr(clamp32(dr - dl) * iwb, 16));
            p.vr = clamp32(dr * rate);
            p.vl = clamp32(dl * rate);
            p.vlin = clamp32(step * rate);
            p.vang = clamp32(turn * rate);
            sin_cos(ph, c, s);
            px = clamp32(px + fshr(step * c, 30));
            py = clamp32(py + fshr(step * s, 30));
            ph = wrap_hdg(ph + turn);
        end
        p.x = px; p.y = py; p.hdg = ph;
    endtask

    // Check each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        pose_t got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.x = m_axis_tdata[31:0];
            got.y = m_axis_tdata[63:32];
            got.hdg = m_axis_tdata[82:64];
            got.vr = m_axis_tdata[114:83];
            got.vl = m_axis_tdata[146:115];
            got.vlin = m_axis_tdata[178:147];
            got.vang = m_axis_tdata[210:179];
            if (pose_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
            end else begin
                want = pose_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch x %0d/%0d y %0d/%0d h %0d/%0d vr %0d/%0d vl %0d/%0d v %0d/%0d w %0d/%0d",
                            want.x, got.x, want.y, got.y, want.hdg, got.hdg,
                            want.vr, got.vr, want.vl, got.vl, want.vlin, got.vlin,
                            want.vang, got.vang);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("differential_drive_odometry regression: fail");
            $finish;
        end
    end

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
        return $urandom_range(0, 3);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int g;
        m_axis_tready = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                m_axis_tready <= 0;
                repeat (400) @(negedge i_clk);
                long_hold = 0;
            end
            if (hold_rx) m_axis_tready <= 1;
            else if ($urandom_range(0, 2) == 0) begin
                g = gap_len();
                if (g > 0) begin
                    m_axis_tready <= 0;
                    repeat (g) @(negedge i_clk);
                end
                m_axis_tready <= 1;
            end else m_axis_tready <= 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            REG_METRES_PER_COUNT: mpc = v;
            REG_INV_WHEEL_BASE:   iwb = v[30:0];
            REG_SAMPLE_RATE:      rate = v[15:0];
            REG_INVERT_LEFT:      inv_left = v[0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pose_q.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    // Offer one item at the falling edge and hold it until the input transfer
    task automatic send_item(input row_t r, input bit use_gap);
        pose_t p;
        int g;
        if (use_gap) begin
            g = gap_len();
            repeat (g) @(negedge i_clk);
        end
        s_axis_tvalid = 1;
        s_axis_tuser = r.kind;
        s_axis_tdata = {5'd0, r.sh, r.sy, r.sx, r.lc, r.rc};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        odometry_step(r, p);
        if (r.has_pose && p !== r.pose) begin
            errors++;
            if (errors <= 10) $display("table row disagrees with predictor");
        end
        pose_q.push_back(p);
        @(negedge i_clk);
        s_axis_tvalid = 0;
    endtask

    function automatic row_t mk(logic k, logic [31:0] rc, logic [31:0] lc,
                                logic [31:0] sx, logic [31:0] sy, logic [18:0] sh);
        row_t r;
        r.kind = k; r.rc = rc; r.lc = lc; r.sx = sx; r.sy = sy; r.sh = sh;
        r.has_pose = 0; r.pose = '0;
        return r;
    endfunction

    function automatic row_t rand_row(ref longint rr, ref longint ll);
        row_t r;
        if ($urandom_range(0, 15) == 0) begin
            r = mk(KIND_SET_POSE, $urandom, $urandom, $urandom, $urandom, 19'($urandom));
        end else if ($urandom_range(0, 9) == 0) begin
            r = mk(KIND_SAMPLE, $urandom, $urandom, $urandom, $urandom, 19'($urandom));
        end else begin
            // Typical motion: small count increments
            rr += $signed($urandom_range(0, 400)) - 200;
            ll += $signed($urandom_range(0, 400)) - 200;
            r = mk(KIND_SAMPLE, 32'(rr), 32'(ll), $urandom, $urandom, 19'($urandom));
        end
        return r;
    endfunction

    initial begin
        row_t dir[$];
        row_t r;
        longint rr, ll;
        pose_t zp;
        i_rst_n = 0;
        s_axis_tvalid = 0; s_axis_tuser = 0; s_axis_tdata = '0;
        i_cfg_we = 0; i_cfg_idx = '0; i_cfg_data = '0;
        mpc = 429497; iwb = 655360; rate = 250; inv_left = 1;
        prev_r = 0; prev_l = 0; px = 0; py = 0; ph = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1;

        // Directed table: zero motion after reset, extremes, set pose, wraps
        zp = '0;
        r = mk(KIND_SAMPLE, 0, 0, 0, 0, 0); r.has_pose = 1; r.pose = zp; dir.push_back(r);
        r = mk(KIND_SET_POSE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h8000_0000, 19'sd205887);
        r.has_pose = 1; r.pose = '{32'h7FFF_FFFF, 32'h8000_0000, 19'sd205887, 0, 0, 0, 0};
        dir.push_back(r);
        dir.push_back(mk(KIND_SET_POSE, 0, 0, 0, 0, 19'h3FFFF));
        dir.push_back(mk(KIND_SET_POSE, 0, 0, 0, 0, 19'h40000));
        dir.push_back(mk(KIND_SET_POSE, 0, 0, 1000, -1000, 19'sd150000));
        dir.push_back(mk(KIND_SAMPLE, 100000, 100000, 0, 0, 0));
        dir.push_back(mk(KIND_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0));
        dir.push_back(mk(KIND_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0));
        dir.push_back(mk(KIND_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0));
        dir.push_back(mk(KIND_SET_POSE, 0, 0, 0, 0, -19'sd205887));
        dir.push_back(mk(KIND_SAMPLE, 5000, -6000, 0, 0, 0));
        dir.push_back(mk(KIND_SAMPLE, 2000000, -2000000, 0, 0, 0));
        dir.push_back(mk(KIND_SAMPLE, -3000000, 3000000, 0, 0, 0));
        dir.push_back(mk(KIND_SET_POSE, 0, 0, 32'h7FFF0000, 32'h7FFF0000, 19'sd51000));
        dir.push_back(mk(KIND_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0));
        foreach (dir[i]) send_item(dir[i], 0);
        drain();

        // Extreme register settings, including zeros
        write_reg(REG_METRES_PER_COUNT, 32'hFFFF_FFFF);
        write_reg(REG_INV_WHEEL_BASE, 32'h7FFF_FFFF);
        write_reg(REG_SAMPLE_RATE, 16'hFFFF);
        write_reg(REG_INVERT_LEFT, 0);
        dir.delete();
        dir.push_back(mk(KIND_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0));
        dir.push_back(mk(KIND_SAMPLE, 12345, -54321, 0, 0, 0));
        foreach (dir[i]) send_item(dir[i], 0);
        drain();
        write_reg(REG_METRES_PER_COUNT, 0);
        write_reg(REG_INV_WHEEL_BASE, 0);
        write_reg(REG_SAMPLE_RATE, 0);
        send_item(mk(KIND_SAMPLE, 777, 888, 0, 0, 0), 0);
        drain();

        // Random phases over several settings
        rr = 0; ll = 0;
        for (int ph_i = 0; ph_i < 5; ph_i++) begin
            write_reg(REG_METRES_PER_COUNT, ph_i == 0 ? 429497 : $urandom);
            write_reg(REG_INV_WHEEL_BASE, ph_i == 0 ? 655360 : $urandom_range(1, 32'h7FFF_FFFF));
            write_reg(REG_SAMPLE_RATE, ph_i == 4 ? 1 : $urandom_range(1, 65535));
            write_reg(REG_INVERT_LEFT, $urandom_range(0, 1));
            for (int k = 0; k < N_RANDOM / 5; k++) begin
                if (ph_i == 1 && k == 10) long_hold = 1;
                if (ph_i == 2 && k == 20) begin
                    while (pose_q.size() != 0) @(negedge i_clk);
                end
                send_item(rand_row(rr, ll), $urandom_range(0, 4) != 0);
            end
            drain();
        end

        hold_rx = 1;
        drain();
        if (errors == 0 && pose_q.size() == 0)
            $display("differential_drive_odometry regression: pass");
        else
            $display("differential_drive_odometry regression: fail");
        $finish;
    end
endmodule
